[rtl/tsq_pkg.sv]
// Shared types and constants of the deadline-sorted timer queue.
package tsq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int MAX_RESULTS  = 16;
   localparam int TIME_W       = 48;
   localparam int DELAY_W      = 32;
   localparam int QUEUE_W      = 4;
   localparam int TAG_W        = 16;
   localparam int INDEX_W      = 32;
   localparam int REQ_DATA_W   = 88;
   localparam int RSP_DATA_W   = 56;
   localparam int COUNT_W      = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   localparam logic KIND_TICK     = 1'b0;
   localparam logic KIND_SCHEDULE = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]  deadline;
      logic [QUEUE_W-1:0] queue;
      logic [TAG_W-1:0]   tag;
      logic [INDEX_W-1:0] index;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type data;
   } slot_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT
   } chain_op_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      chain_op_type op;
      entry_type    entry;
   } chain_cmd_type;

   // What the controller sees of the chain.
   typedef struct packed {
      slot_type head;
      slot_type next;
      logic     tail_valid;
   } chain_status_type;

endpackage

[rtl/tsq_cell.sv]
// One slot of the sorted chain: holds a job and trades it with its neighbours.
module tsq_cell
   import tsq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  slot_type      left_slot,
   input  logic          left_keep,
   input  slot_type      right_slot,
   output slot_type      slot,
   output logic          keep
);

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;

   // A cell keeps its job on insertion when that job is not later than the new one.
   assign keep = valid_ff && (data_ff.deadline <= cmd.entry.deadline);
   assign slot = '{valid: valid_ff, data: data_ff};

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (cmd.op)
         OP_HOLD: begin
         end
         OP_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  valid_in = 1'b1;
                  data_in  = cmd.entry;
               end else begin
                  valid_in = left_slot.valid;
                  data_in  = left_slot.data;
               end
            end
         end
         OP_SHIFT: begin
            valid_in = right_slot.valid;
            data_in  = right_slot.data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[rtl/tsq_chain.sv]
// Row of slot cells kept in deadline order, head in the first cell.
module tsq_chain
   import tsq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  chain_cmd_type    cmd,
   output chain_status_type status
);

   slot_type slots [QUEUE_DEPTH];
   logic     keeps [QUEUE_DEPTH];

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         slot_type left_slot, right_slot;
         logic     left_keep;

         if (i == 0) begin : g_first
            assign left_slot = '{valid: 1'b1, data: cmd.entry};
            assign left_keep = 1'b1;
         end else begin : g_inner
            assign left_slot = slots[i-1];
            assign left_keep = keeps[i-1];
         end

         if (i == QUEUE_DEPTH-1) begin : g_last
            assign right_slot = '0;
         end else begin : g_body
            assign right_slot = slots[i+1];
         end

         tsq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .left_slot  (left_slot),
            .left_keep  (left_keep),
            .right_slot (right_slot),
            .slot       (slots[i]),
            .keep       (keeps[i])
         );
      end
   endgenerate

   assign status.head       = slots[0];
   assign status.next       = slots[1];
   assign status.tail_valid = slots[QUEUE_DEPTH-1].valid;

endmodule

[rtl/deadline_sorted_timer_queue_top.sv]
// Top level of the deadline-sorted timer queue: control, time base and result register.
//
// Input items arrive on the req_ channel. req_tuser carries the kind: a tick
// advances the time by one unit, a schedule item enters a job with its delay.
// Results leave on the rsp_ channel from a single output register.
// A schedule item gives one status item, registered from the schedule state:
// accepted, or full when every slot of the chain is taken. It is inserted
// by the whole chain of cells comparing deadlines at once.
// A tick advances the time, then dispatches the due jobs at the head one by
// one; each dispatched job shifts the chain by one cell, and rsp_tlast marks
// the final dispatch of that tick. A tick with nothing due gives no item.
// The next input item is taken once the current one is finished.
// A stalled receiver holds the output register and with it the sequencer.
// Reset (synchronous, active high) empties the chain and sets the time to zero.
module deadline_sorted_timer_queue_top
   import tsq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // delay[31:0], target_queue[35:32], work_tag[51:36], work_index[83:52]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_queue[3:0], out_tag[19:4], out_index[51:20]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // is_dispatch[0], status[1]
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCHED,
      ST_DRAIN
   } state_type;

   state_type            state_ff;
   logic [TIME_W-1:0]    now_ff;
   entry_type            item_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [1:0]           rsp_tuser_ff;
   logic                 rsp_tlast_ff;

   chain_cmd_type    cmd;
   chain_status_type chain_st;
   logic             out_free;
   logic             head_due;
   logic             next_due;
   logic             dispatch_last;
   logic             rsp_load;

   tsq_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (chain_st)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign head_due = chain_st.head.valid && (chain_st.head.data.deadline <= now_ff);
   assign next_due = chain_st.next.valid && (chain_st.next.data.deadline <= now_ff);
   assign dispatch_last = !next_due || (count_ff == COUNT_W'(MAX_RESULTS - 1));
   assign rsp_load = out_free &&
                     ((state_ff == ST_SCHED) || ((state_ff == ST_DRAIN) && head_due));

   always_comb begin
      cmd.entry = item_ff;
      cmd.op    = OP_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SCHED: begin
            if (out_free && !chain_st.tail_valid) begin
               cmd.op = OP_INSERT;
            end
         end
         ST_DRAIN: begin
            if (out_free && head_due) begin
               cmd.op = OP_SHIFT;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  if (req_tuser == KIND_SCHEDULE) begin
                     item_ff.deadline <= now_ff + TIME_W'(req_tdata[31:0]);
                     item_ff.queue    <= req_tdata[35:32];
                     item_ff.tag      <= req_tdata[51:36];
                     item_ff.index    <= req_tdata[83:52];
                     state_ff         <= ST_SCHED;
                  end else begin
                     now_ff   <= now_ff + TIME_W'(1);
                     count_ff <= '0;
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_SCHED: begin
               if (out_free) begin
                  rsp_tdata_ff  <= '0;
                  rsp_tuser_ff  <= {chain_st.tail_valid, 1'b0};
                  rsp_tlast_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_DRAIN: begin
               if (!head_due) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_tdata_ff  <= {4'b0, chain_st.head.data.index,
                                    chain_st.head.data.tag, chain_st.head.data.queue};
                  rsp_tuser_ff  <= 2'b01;
                  rsp_tlast_ff  <= dispatch_last;
                  count_ff      <= count_ff + COUNT_W'(1);
                  if (dispatch_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // The valid slots always form a prefix of the chain.
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      chain_st.tail_valid |-> chain_st.head.valid)
      else $error("chain tail holds a job while the head is empty");

   // A dispatch that is not the final one leaves a due job at the head.
   a_more_due: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && !rsp_tlast) |-> (state_ff == ST_DRAIN && head_due))
      else $error("dispatch without tlast but no further due job");

   // Time moves only on an accepted tick.
   a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready && req_tuser == KIND_TICK) |=> $stable(now_ff))
      else $error("time changed without a tick");

endmodule

[bench/deadline_sorted_timer_queue_top_tb.sv]
// Self-checking testbench of the deadline-sorted timer queue with a built-in shadow queue.
`timescale 1ns / 100ps

module deadline_sorted_timer_queue_top_tb;
   import tsq_pkg::*;

   localparam bit STATUS_DONE     = 1'b0;
   localparam bit STATUS_FULL     = 1'b1;
   localparam bit RESULT_STATUS   = 1'b0;
   localparam bit RESULT_DISPATCH = 1'b1;
   localparam int RANDOM_ITEMS    = 148;

   typedef struct {
      bit                 kind;
      bit [DELAY_W-1:0]   delay;
      bit [QUEUE_W-1:0]   queue;
      bit [TAG_W-1:0]     tag;
      bit [INDEX_W-1:0]   index;
   } job_item;

   typedef struct {
      bit                 dispatch;
      bit                 status;
      bit [QUEUE_W-1:0]   queue;
      bit [TAG_W-1:0]     tag;
      bit [INDEX_W-1:0]   index;
      bit                 last;
   } job_result;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = KIND_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   job_item   job_feed[$];
   job_result awaited_results[$];

   // Shadow copy of the block's state.
   bit [TIME_W-1:0] shadow_now;
   entry_type       shadow_jobs[QUEUE_DEPTH];
   int              shadow_held;

   int feed_total;
   int accepted_count;
   int schedule_count;
   int tick_count;
   int dispatch_seen;
   int full_seen;
   int error_count;
   int tx_gap;
   int tx_calm;
   int rx_stall;
   int rx_calm;
   bit tail_phase;

   deadline_sorted_timer_queue_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   assign tail_phase = accepted_count >= feed_total - feed_total / 5;

   // Returns the length of an idle burst to start now, or zero. Calm stretches
   // hold idling off for a while, and the tail of the run has none at all.
   function automatic int pause_len(inout int calm_left);
      if (tail_phase) return 0;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 5) == 0) begin
         calm_left = $urandom_range(10, 60);
         return 0;
      end
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
   endfunction

   function automatic void step_shadow_queue(job_item it);
      job_result     res;
      bit [TIME_W-1:0] deadline;
      int            pos;
      int            due;
      int            i;
      res = '{default: 0};
      if (it.kind == KIND_SCHEDULE) begin
         schedule_count++;
         res.dispatch = RESULT_STATUS;
         res.last     = 1'b1;
         if (shadow_held >= QUEUE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            res.status = STATUS_DONE;
            deadline = shadow_now + TIME_W'(it.delay);
            pos = 0;
            // Equal deadlines go behind the jobs already held.
            while (pos < shadow_held && shadow_jobs[pos].deadline <= deadline) pos++;
            for (i = shadow_held; i > pos; i--) shadow_jobs[i] = shadow_jobs[i-1];
            shadow_jobs[pos].deadline = deadline;
            shadow_jobs[pos].queue    = it.queue;
            shadow_jobs[pos].tag      = it.tag;
            shadow_jobs[pos].index    = it.index;
            shadow_held++;
         end
         awaited_results.push_back(res);
      end else begin
         tick_count++;
         shadow_now = shadow_now + 1'b1;
         due = 0;
         while (due < shadow_held && due < MAX_RESULTS &&
                shadow_jobs[due].deadline <= shadow_now) due++;
         for (i = 0; i < due; i++) begin
            res.dispatch = RESULT_DISPATCH;
            res.status   = STATUS_DONE;
            res.queue    = shadow_jobs[i].queue;
            res.tag      = shadow_jobs[i].tag;
            res.index    = shadow_jobs[i].index;
            res.last     = (i == due - 1);
            awaited_results.push_back(res);
         end
         for (i = 0; i + due < shadow_held; i++) shadow_jobs[i] = shadow_jobs[i+due];
         shadow_held -= due;
      end
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic job_item it_from_bus(logic kind, logic [REQ_DATA_W-1:0] data);
      job_item it;
      it.kind  = kind;
      it.delay = data[31:0];
      it.queue = data[35:32];
      it.tag   = data[51:36];
      it.index = data[83:52];
      return it;
   endfunction

   // Driver: offers items from the feed, predicting each one as it is accepted.
   always @(posedge clock) begin
      bit      next_valid;
      int      burst;
      job_item it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            step_shadow_queue(it_from_bus(req_tuser, req_tdata));
            accepted_count++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (job_feed.size() > 0) begin
               burst = pause_len(tx_calm);
               if (burst > 0) begin
                  tx_gap = burst - 1;
               end else begin
                  it = job_feed.pop_front();
                  req_tuser  <= it.kind;
                  req_tdata  <= {4'b0, it.index, it.tag, it.queue, it.delay};
                  next_valid = 1'b1;
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      int burst;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_tready <= 1'b0;
      end else begin
         burst = pause_len(rx_calm);
         if (burst > 0) rx_stall = burst - 1;
         rsp_tready <= (burst == 0);
      end
   end

   // Monitor: every accepted result is held against the oldest expectation.
   always @(posedge clock) begin
      job_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual tuser=%b tdata=0x%0h last=%b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (want.dispatch) dispatch_seen++;
            if (want.status == STATUS_FULL) full_seen++;
            check_field("is_dispatch", want.dispatch, rsp_tuser[0]);
            check_field("status", want.status, rsp_tuser[1]);
            check_field("out_queue", want.queue, rsp_tdata[3:0]);
            check_field("out_tag", want.tag, rsp_tdata[19:4]);
            check_field("out_index", want.index, rsp_tdata[51:20]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   task automatic add_job(bit kind, bit [DELAY_W-1:0] delay, bit [QUEUE_W-1:0] queue,
                          bit [TAG_W-1:0] tag, bit [INDEX_W-1:0] index);
      job_item it;
      it.kind  = kind;
      it.delay = delay;
      it.queue = queue;
      it.tag   = tag;
      it.index = index;
      job_feed.push_back(it);
   endtask

   task automatic add_random_job();
      bit [31:0] rnd;
      bit [31:0] delay;
      rnd = $urandom();
      // A few very long delays; they stay queued for the rest of the run.
      delay = ($urandom_range(0, 39) == 0) ? $urandom() : $urandom_range(0, 6);
      add_job(KIND_SCHEDULE, delay, rnd[3:0], rnd[31:16], $urandom());
   endtask

   initial begin
      int made;
      int sched_pct;
      int seg;
      int i;
      shadow_now  = '0;
      shadow_held = 0;

      // Sixteen jobs on one deadline fill the queue in arrival order, with the
      // field extremes among them; the next schedule is turned away.
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         case (i % 3)
            0: add_job(KIND_SCHEDULE, 1, 4'h0, 16'h0000, 32'h0000_0000);
            1: add_job(KIND_SCHEDULE, 1, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
            default: add_job(KIND_SCHEDULE, 1, QUEUE_W'(i), TAG_W'(i * 16'h1111), $urandom());
         endcase
      end
      add_job(KIND_SCHEDULE, 3, 4'h5, 16'h5555, 32'h5555_5555);
      // One tick drains the whole queue at once.
      add_job(KIND_TICK, 0, 0, 0, 0);
      add_job(KIND_SCHEDULE, 32'hFFFF_FFFF, 4'hA, 16'hAAAA, 32'hAAAA_AAAA);
      add_job(KIND_SCHEDULE, 0, 4'h3, 16'h1234, 32'h89AB_CDEF);
      add_job(KIND_TICK, 0, 0, 0, 0);
      // Nothing is due here, so this tick gives no item.
      add_job(KIND_TICK, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);

      made = 0;
      while (made < RANDOM_ITEMS) begin
         sched_pct = $urandom_range(30, 80);
         seg = $urandom_range(10, 30);
         if (seg > RANDOM_ITEMS - made) seg = RANDOM_ITEMS - made;
         for (i = 0; i < seg; i++) begin
            if ($urandom_range(1, 100) <= sched_pct) add_random_job();
            else add_job(KIND_TICK, $urandom(), $urandom(), $urandom(), $urandom());
         end
         made += seg;
      end
      feed_total = job_feed.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < feed_total || awaited_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d items: %0d schedules and %0d ticks.",
               feed_total, schedule_count, tick_count);
      $display("Checked %0d dispatched jobs and %0d schedules turned away as full.",
               dispatch_seen, full_seen);
      if (error_count == 0) begin
         $display("deadline_sorted_timer_queue_top_tb: clean");
      end else begin
         $display("deadline_sorted_timer_queue_top_tb: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d of %0d items accepted and %0d results outstanding.",
               accepted_count, feed_total, awaited_results.size());
      $display("deadline_sorted_timer_queue_top_tb: errors");
      $finish;
   end

endmodule

[deadline_sorted_timer_queue_top.f]
rtl/tsq_pkg.sv
rtl/tsq_cell.sv
rtl/tsq_chain.sv
rtl/deadline_sorted_timer_queue_top.sv
bench/deadline_sorted_timer_queue_top_tb.sv
